FILE: hdl/ffbsa_pkg.sv
// Shared types and constants for the first-fit block space allocator.
// Used by ffbsa_cell and first_fit_block_space_allocator_top; no dependencies.
package ffbsa_pkg;

    // Default table depth (number of block cells in the chain)
    localparam int MAX_BLOCKS_DEF = 64;

    // Field widths fixed by the interface
    localparam int SIZE_W  = 16;
    localparam int IDX_W   = 6;
    localparam int ADDR_W  = 22;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Reachable block indices through the release field
    localparam int IDX_SPAN = 64;

    // File header in front of block 0
    localparam logic [ADDR_W-1:0] HEADER_BYTES = 22'd8;

    // Block size after reset
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 16'd4096;

    // Operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_SPACE    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_RELEASE = 2'd2;

    // Request payload
    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] record_size;
        logic [IDX_W-1:0]  block_index;
    } req_t;

    // Response payload
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [IDX_W-1:0]   chosen_block;
        logic [ADDR_W-1:0]  byte_address;
        logic [COUNT_W-1:0] blocks_in_use;
    } rsp_t;

    // Request token that walks the cell chain
    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  idx;
        logic              done;     // some cell has answered
        logic              opened;   // answering cell opened a new block
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  block;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;     // byte address of the next cell's block
    } token_t;

endpackage

FILE: hdl/ffbsa_cell.sv
// One block cell: holds free bytes and record count of one block and
// serves the request token as it passes. Depends on ffbsa_pkg.
module ffbsa_cell #(
    parameter int MAX_BLOCKS = ffbsa_pkg::MAX_BLOCKS_DEF,
    parameter int INDEX      = 0,
    parameter int OPEN_W     = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ffbsa_pkg::SIZE_W-1:0]  block_size,
    input  logic [OPEN_W-1:0]             open_blocks,
    input  logic                          tok_valid_in,
    input  ffbsa_pkg::token_t             tok_in,
    output logic                          tok_valid_out,
    output ffbsa_pkg::token_t             tok_out
);

    localparam logic [OPEN_W-1:0]            MY_POS   = OPEN_W'(INDEX);
    localparam logic [ffbsa_pkg::IDX_W-1:0]  MY_IDX   =
        ffbsa_pkg::IDX_W'(INDEX % ffbsa_pkg::IDX_SPAN);
    localparam bit                           IDX_REACH = (INDEX < ffbsa_pkg::IDX_SPAN);

    // Block state (payload, no reset)
    logic [ffbsa_pkg::SIZE_W-1:0] free_reg, free_next;
    logic [ffbsa_pkg::SIZE_W-1:0] count_reg, count_next;
    logic                         state_we;

    ffbsa_pkg::token_t tok_reg, tok_next;
    logic              tok_valid_reg;

    logic                         live;
    logic                         is_new;
    logic                         idx_hit;
    logic [ffbsa_pkg::SIZE_W-1:0] used;
    logic [ffbsa_pkg::SIZE_W:0]   rel_sum;

    assign live    = (MY_POS < open_blocks);
    assign is_new  = (MY_POS == open_blocks);
    assign idx_hit = IDX_REACH && (tok_in.idx == MY_IDX);
    assign used    = (free_reg <= block_size) ? (block_size - free_reg) : '0;
    assign rel_sum = {1'b0, free_reg} + {1'b0, tok_in.size};

    // Serve the token
    always_comb
    begin
        tok_next      = tok_in;
        tok_next.base = tok_in.base + ffbsa_pkg::ADDR_W'(block_size);
        free_next     = free_reg;
        count_next    = count_reg;
        state_we      = 1'b0;
        if (tok_valid_in && !tok_in.done)
        begin
            if (tok_in.op == ffbsa_pkg::OP_ALLOC)
            begin
                // live and is_new never hold together; neither means pass on
                if (live && (free_reg >= tok_in.size))
                begin
                    free_next     = free_reg - tok_in.size;
                    count_next    = count_reg + 16'd1;
                    state_we      = 1'b1;
                    tok_next.done   = 1'b1;
                    tok_next.status = ffbsa_pkg::STATUS_OK;
                    tok_next.block  = MY_IDX;
                    tok_next.addr   = tok_in.base + ffbsa_pkg::ADDR_W'(used);
                end
                else if (is_new && (tok_in.size <= block_size))
                begin
                    // first block past the open ones: open it here
                    free_next     = block_size - tok_in.size;
                    count_next    = 16'd1;
                    state_we      = 1'b1;
                    tok_next.done   = 1'b1;
                    tok_next.opened = 1'b1;
                    tok_next.status = ffbsa_pkg::STATUS_OK;
                    tok_next.block  = MY_IDX;
                    tok_next.addr   = tok_in.base;
                end
            end
            else if (idx_hit)
            begin
                tok_next.done  = 1'b1;
                tok_next.block = tok_in.idx;
                tok_next.addr  = '0;
                if (live && (count_reg != '0) && (rel_sum <= {1'b0, block_size}))
                begin
                    free_next       = rel_sum[ffbsa_pkg::SIZE_W-1:0];
                    count_next      = count_reg - 16'd1;
                    state_we        = 1'b1;
                    tok_next.status = ffbsa_pkg::STATUS_OK;
                end
                else
                begin
                    tok_next.status = ffbsa_pkg::STATUS_BAD_RELEASE;
                end
            end
        end
    end

    // Block state update
    always_ff @(posedge clk)
    begin
        if (state_we)
        begin
            free_reg  <= free_next;
            count_reg <= count_next;
        end
        tok_reg <= tok_next;
    end

    // Token valid to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

FILE: hdl/first_fit_block_space_allocator_top.sv
// First-fit free-space map for a file of fixed-size blocks: top level.
// Depends on ffbsa_pkg and ffbsa_cell.
//
// Usage:
//   req channel (req_valid/req_ready/req): allocate (op 0) or release (op 1).
//   rsp channel (rsp_valid/rsp_ready/rsp): one response per request with
//   status, chosen block, record byte address and blocks in use.
//   cfg_we/cfg_wdata writes block_size; write only while no request is open.
// Request flow:
//   A request token walks a chain of MAX_BLOCKS cells, one cell per cycle,
//   then passes the holding register and the response register. One
//   request is in flight at a time: a new request is taken only once the
//   result of the last one has moved on to the response register.
// Reset:
//   No blocks open, block_size 4096, both channels empty. Block table
//   entries hold no defined value until their block is opened.
// Stalls:
//   A response waiting on rsp_ready does not block the next request; a
//   second finished result waits in a holding register until rsp frees up.
module first_fit_block_space_allocator_top #(
    parameter int MAX_BLOCKS = ffbsa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ffbsa_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  ffbsa_pkg::req_t              req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output ffbsa_pkg::rsp_t              rsp
);

    localparam int OPEN_W = $clog2(MAX_BLOCKS + 1);

    logic [ffbsa_pkg::SIZE_W-1:0] block_size_reg;
    logic [OPEN_W-1:0]            open_reg, open_next;
    logic                         busy_reg;
    logic                         pend_valid_reg;
    ffbsa_pkg::rsp_t              pend_reg, fin;
    logic                         rsp_valid_reg;
    ffbsa_pkg::rsp_t              rsp_reg;

    logic                         req_xfer;
    logic                         pend_move;

    // Token chain: entry 0 is the injection register, entry k leaves cell k-1
    logic              tok_vld [MAX_BLOCKS+1];
    ffbsa_pkg::token_t tok     [MAX_BLOCKS+1];
    ffbsa_pkg::token_t tok_inj;

    assign req_xfer  = req_valid && req_ready;
    assign pend_move = pend_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !busy_reg;

    // Fresh token from the request
    always_comb
    begin
        tok_inj        = '0;
        tok_inj.op     = req.op;
        tok_inj.size   = req.record_size;
        tok_inj.idx    = req.block_index;
        tok_inj.base   = ffbsa_pkg::HEADER_BYTES;
        tok_inj.status = ffbsa_pkg::STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            tok[0] <= tok_inj;
        end
    end

    // Cell chain
    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            ffbsa_cell #(
                .MAX_BLOCKS (MAX_BLOCKS),
                .INDEX      (g),
                .OPEN_W     (OPEN_W)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .block_size    (block_size_reg),
                .open_blocks   (open_reg),
                .tok_valid_in  (tok_vld[g]),
                .tok_in        (tok[g]),
                .tok_valid_out (tok_vld[g+1]),
                .tok_out       (tok[g+1])
            );
        end
    endgenerate

    // Wrap-up of a token that leaves the chain
    assign open_next = open_reg + OPEN_W'(tok[MAX_BLOCKS].opened);

    always_comb
    begin
        fin               = '0;
        fin.blocks_in_use = ffbsa_pkg::COUNT_W'(open_next);
        priority if (tok[MAX_BLOCKS].done)
        begin
            fin.status       = tok[MAX_BLOCKS].status;
            fin.chosen_block = tok[MAX_BLOCKS].block;
            fin.byte_address = tok[MAX_BLOCKS].addr;
        end
        else if (tok[MAX_BLOCKS].op == ffbsa_pkg::OP_ALLOC)
        begin
            // no fit and no room for a new block
            fin.status = ffbsa_pkg::STATUS_NO_SPACE;
        end
        else
        begin
            // released block was never opened
            fin.status       = ffbsa_pkg::STATUS_BAD_RELEASE;
            fin.chosen_block = tok[MAX_BLOCKS].idx;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tok_vld[MAX_BLOCKS])
        begin
            pend_reg <= fin;
        end
        if (pend_move)
        begin
            rsp_reg <= pend_reg;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= ffbsa_pkg::BLOCK_SIZE_RST;
            open_reg       <= '0;
            busy_reg       <= 1'b0;
            tok_vld[0]     <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_size_reg <= cfg_wdata;
            end
            tok_vld[0] <= req_xfer;
            if (tok_vld[MAX_BLOCKS])
            begin
                open_reg <= open_next;
            end
            if (req_xfer)
            begin
                busy_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                busy_reg <= 1'b0;
            end
            if (tok_vld[MAX_BLOCKS])
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for first_fit_block_space_allocator_top.
// Depends on ffbsa_pkg and the RTL under hdl/; drives a directed table, then
// random allocate/release traffic over several block sizes.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_BLK = ffbsa_pkg::MAX_BLOCKS_DEF;
    localparam int DIR_N   = 21;
    localparam int N_PHASE = 5;

    // One row of the directed table
    typedef struct {
        ffbsa_pkg::req_t rq;
        bit              known;     // exp holds a hand-typed response
        ffbsa_pkg::rsp_t exp;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [ffbsa_pkg::SIZE_W-1:0] cfg_wdata;
    logic       req_valid;
    logic       req_ready;
    ffbsa_pkg::req_t req;
    logic       rsp_valid;
    logic       rsp_ready;
    ffbsa_pkg::rsp_t rsp;

    // Free-space map mirror
    logic [ffbsa_pkg::SIZE_W-1:0] map_free  [MAX_BLK];
    logic [ffbsa_pkg::SIZE_W-1:0] map_count [MAX_BLK];
    int          map_open  = 0;
    int unsigned map_bsize = ffbsa_pkg::BLOCK_SIZE_RST;

    // Responses still due, oldest first
    ffbsa_pkg::rsp_t want_rsp_q[$];

    // Records currently placed, for well-formed releases
    int unsigned live_blk[$];
    int unsigned live_size[$];

    dir_row_t dir_tbl[DIR_N];

    int  err_cnt   = 0;
    int  n_ok      = 0;
    int  n_nospace = 0;
    int  n_badrel  = 0;
    int  n_sent    = 0;
    int  hold_left = 0;
    bit  calm      = 1'b0;

    first_fit_block_space_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // Run limit
    initial
    begin
        #2_000_000;
        $display("** first_fit_block_space_allocator_top: FAILED **");
        $finish;
    end

    // Apply one request to the mirrored map and return the response it earns
    function automatic ffbsa_pkg::rsp_t space_map_apply(ffbsa_pkg::req_t r);
        ffbsa_pkg::rsp_t o;
        int unsigned     sz;
        int unsigned     fr;
        int unsigned     used;
        int unsigned     blk;
        longint unsigned addr;
        bit              hit;
        int              i;
        o   = '0;
        hit = 1'b0;
        sz  = r.record_size;
        if (r.op == ffbsa_pkg::OP_ALLOC)
        begin
            // first fit over the open blocks
            for (i = 0; i < map_open; i++)
            begin
                if (!hit && map_free[i] >= sz)
                begin
                    fr   = map_free[i];
                    used = (fr <= map_bsize) ? map_bsize - fr : 0;
                    addr = longint'(ffbsa_pkg::HEADER_BYTES) + longint'(i) * map_bsize
                           + used;
                    map_free[i]    = ffbsa_pkg::SIZE_W'(fr - sz);
                    map_count[i]   = map_count[i] + 1'b1;
                    o.chosen_block = ffbsa_pkg::IDX_W'(i);
                    o.byte_address = ffbsa_pkg::ADDR_W'(addr);
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                if (map_open >= MAX_BLK || sz > map_bsize)
                    o.status = ffbsa_pkg::STATUS_NO_SPACE;
                else
                begin
                    // open a fresh block
                    addr = longint'(ffbsa_pkg::HEADER_BYTES)
                           + longint'(map_open) * map_bsize;
                    map_free[map_open]  = ffbsa_pkg::SIZE_W'(map_bsize - sz);
                    map_count[map_open] = 1;
                    o.chosen_block = ffbsa_pkg::IDX_W'(map_open);
                    o.byte_address = ffbsa_pkg::ADDR_W'(addr);
                    map_open++;
                end
            end
        end
        else
        begin
            blk = r.block_index;
            o.chosen_block = r.block_index;
            if (blk >= map_open || map_count[blk] == 0 || map_free[blk] + sz > map_bsize)
                o.status = ffbsa_pkg::STATUS_BAD_RELEASE;
            else
            begin
                map_free[blk]  = ffbsa_pkg::SIZE_W'(map_free[blk] + sz);
                map_count[blk] = map_count[blk] - 1'b1;
            end
        end
        o.blocks_in_use = ffbsa_pkg::COUNT_W'(map_open);
        return o;
    endfunction

    function automatic dir_row_t mk_row(logic op, int size, int idx, bit known,
                                        logic [ffbsa_pkg::STAT_W-1:0] st, int blk,
                                        int addr, int biu);
        dir_row_t d;
        d.rq    = '{op: op, record_size: ffbsa_pkg::SIZE_W'(size),
                    block_index: ffbsa_pkg::IDX_W'(idx)};
        d.known = known;
        d.exp   = '{status: st, chosen_block: ffbsa_pkg::IDX_W'(blk),
                    byte_address: ffbsa_pkg::ADDR_W'(addr),
                    blocks_in_use: ffbsa_pkg::COUNT_W'(biu)};
        return d;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (sel < 60)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Random request: allocations of mixed sizes, releases of live records, some noise
    function automatic ffbsa_pkg::req_t pick_request();
        ffbsa_pkg::req_t r;
        int              sel;
        int              k;
        int unsigned     cap;
        r   = '0;
        sel = $urandom_range(0, 99);
        if (sel < 58)
        begin
            r.op          = ffbsa_pkg::OP_ALLOC;
            r.block_index = ffbsa_pkg::IDX_W'($urandom);
            sel = $urandom_range(0, 99);
            cap = (map_bsize / 4 > 1) ? map_bsize / 4 : 1;
            if (sel < 5)
                r.record_size = '0;
            else if (sel < 10)
                r.record_size = ffbsa_pkg::SIZE_W'(map_bsize);
            else if (sel < 15)
                r.record_size = ffbsa_pkg::SIZE_W'($urandom_range(map_bsize, 65535));
            else if (sel < 18)
                r.record_size = '1;
            else
                r.record_size = ffbsa_pkg::SIZE_W'($urandom_range(1, cap));
        end
        else
        begin
            r.op = ffbsa_pkg::OP_RELEASE;
            if (sel < 88 && live_blk.size() != 0)
            begin
                // give back a record that was really placed
                k = $urandom_range(0, live_blk.size() - 1);
                r.block_index = ffbsa_pkg::IDX_W'(live_blk[k]);
                r.record_size = ffbsa_pkg::SIZE_W'(live_size[k]);
                live_blk.delete(k);
                live_size.delete(k);
            end
            else
            begin
                r.record_size = ffbsa_pkg::SIZE_W'($urandom_range(0, 65535));
                if (map_open > 0 && $urandom_range(0, 1))
                    r.block_index = ffbsa_pkg::IDX_W'($urandom_range(0, map_open - 1));
                else
                    r.block_index = ffbsa_pkg::IDX_W'($urandom);
            end
        end
        return r;
    endfunction

    // Offer one request, wait for its transfer, record what must come back
    task automatic issue_request(ffbsa_pkg::req_t item, bit known, ffbsa_pkg::rsp_t fixed);
        ffbsa_pkg::rsp_t pred;
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pred = space_map_apply(item);
        want_rsp_q = {want_rsp_q, (known ? fixed : pred)};
        if (item.op == ffbsa_pkg::OP_ALLOC && pred.status == ffbsa_pkg::STATUS_OK)
        begin
            live_blk  = {live_blk, int'(pred.chosen_block)};
            live_size = {live_size, int'(item.record_size)};
        end
        n_sent++;
    endtask

    // Gap after a transfer; the last one of a phase drops valid
    task automatic after_transfer(bit last);
        int g;
        g = last ? 0 : gap_len();
        if (g > 0 || last)
            req_valid <= 1'b0;
        repeat (g) @(posedge clk);
    endtask

    // Block size is written only with nothing in flight
    task automatic set_block_size(int unsigned v);
        while (want_rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ffbsa_pkg::SIZE_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        map_bsize = v;
    endtask

    // Receiver: random idling plus one long hold-off on request
    initial
    begin
        int idle_left;
        idle_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else if (idle_left > 0)
            begin
                rsp_ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    idle_left = gap_len();
            end
        end
    end

    // Response checker
    always @(posedge clk)
    begin
        ffbsa_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            case (rsp.status)
                ffbsa_pkg::STATUS_OK:       n_ok++;
                ffbsa_pkg::STATUS_NO_SPACE: n_nospace++;
                default:                    n_badrel++;
            endcase
            if (want_rsp_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%t: response with none due: st %0d blk %0d addr %0d used %0d",
                             $realtime, rsp.status, rsp.chosen_block, rsp.byte_address,
                             rsp.blocks_in_use);
            end
            else
            begin
                want = want_rsp_q.pop_front();
                if (rsp.status != want.status || rsp.chosen_block != want.chosen_block ||
                    rsp.byte_address != want.byte_address ||
                    rsp.blocks_in_use != want.blocks_in_use)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("%t: mismatch exp st %0d blk %0d addr %0d used %0d",
                                 $realtime, want.status, want.chosen_block,
                                 want.byte_address, want.blocks_in_use);
                        $display("    got st %0d blk %0d addr %0d used %0d",
                                 rsp.status, rsp.chosen_block, rsp.byte_address,
                                 rsp.blocks_in_use);
                    end
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        int unsigned phase_bsize [N_PHASE];
        int          phase_items [N_PHASE];
        int          p;
        int          n;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        req_valid <= 1'b0;
        req       <= '0;
        for (n = 0; n < MAX_BLK; n++)
        begin
            map_free[n]  = '0;
            map_count[n] = '0;
        end

        // Directed table: rows with known=1 carry a hand-typed response
        dir_tbl[0]  = mk_row(ffbsa_pkg::OP_RELEASE, 0,      0,  1,
                             ffbsa_pkg::STATUS_BAD_RELEASE, 0,  0,    0);
        dir_tbl[1]  = mk_row(ffbsa_pkg::OP_ALLOC,   65535,  0,  1,
                             ffbsa_pkg::STATUS_NO_SPACE,    0,  0,    0);
        dir_tbl[2]  = mk_row(ffbsa_pkg::OP_ALLOC,   4097,   63, 1,
                             ffbsa_pkg::STATUS_NO_SPACE,    0,  0,    0);
        dir_tbl[3]  = mk_row(ffbsa_pkg::OP_ALLOC,   0,      0,  1,
                             ffbsa_pkg::STATUS_OK,          0,  8,    1);
        dir_tbl[4]  = mk_row(ffbsa_pkg::OP_ALLOC,   4096,   0,  1,
                             ffbsa_pkg::STATUS_OK,          0,  8,    1);
        dir_tbl[5]  = mk_row(ffbsa_pkg::OP_ALLOC,   1,      0,  1,
                             ffbsa_pkg::STATUS_OK,          1,  4104, 2);
        dir_tbl[6]  = mk_row(ffbsa_pkg::OP_ALLOC,   0,      0,  0,
                             ffbsa_pkg::STATUS_OK,          0,  0,    0);
        dir_tbl[7]  = mk_row(ffbsa_pkg::OP_RELEASE, 1,      63, 1,
                             ffbsa_pkg::STATUS_BAD_RELEASE, 63, 0,    2);
        dir_tbl[8]  = mk_row(ffbsa_pkg::OP_RELEASE, 1,      2,  1,
                             ffbsa_pkg::STATUS_BAD_RELEASE, 2,  0,    2);
        dir_tbl[9]  = mk_row(ffbsa_pkg::OP_RELEASE, 4097,   0,  1,
                             ffbsa_pkg::STATUS_BAD_RELEASE, 0,  0,    2);
        dir_tbl[10] = mk_row(ffbsa_pkg::OP_RELEASE, 4096,   0,  0,
                             ffbsa_pkg::STATUS_OK,          0,  0,    0);
        dir_tbl[11] = mk_row(ffbsa_pkg::OP_RELEASE, 0,      0,  0,
                             ffbsa_pkg::STATUS_OK,          0,  0,    0);
        dir_tbl[12] = mk_row(ffbsa_pkg::OP_RELEASE, 0,      0,  0,
                             ffbsa_pkg::STATUS_OK,          0,  0,    0);
        dir_tbl[13] = mk_row(ffbsa_pkg::OP_RELEASE, 0,      0,  1,
                             ffbsa_pkg::STATUS_BAD_RELEASE, 0,  0,    2);
        dir_tbl[14] = mk_row(ffbsa_pkg::OP_RELEASE, 'hAAAA, 42, 1,
                             ffbsa_pkg::STATUS_BAD_RELEASE, 42, 0,    2);
        dir_tbl[15] = mk_row(ffbsa_pkg::OP_RELEASE, 'h5555, 21, 1,
                             ffbsa_pkg::STATUS_BAD_RELEASE, 21, 0,    2);
        dir_tbl[16] = mk_row(ffbsa_pkg::OP_ALLOC,   4095,   0,  0,
                             ffbsa_pkg::STATUS_OK,          0,  0,    0);
        dir_tbl[17] = mk_row(ffbsa_pkg::OP_ALLOC,   2,      0,  0,
                             ffbsa_pkg::STATUS_OK,          0,  0,    0);
        dir_tbl[18] = mk_row(ffbsa_pkg::OP_ALLOC,   'h8000, 0,  1,
                             ffbsa_pkg::STATUS_NO_SPACE,    0,  0,    2);
        dir_tbl[19] = mk_row(ffbsa_pkg::OP_ALLOC,   'h7FFF, 0,  1,
                             ffbsa_pkg::STATUS_NO_SPACE,    0,  0,    2);
        dir_tbl[20] = mk_row(ffbsa_pkg::OP_RELEASE, 1,      1,  0,
                             ffbsa_pkg::STATUS_OK,          0,  0,    0);

        // Block size per phase: reset value, extremes, and random middles
        phase_bsize[0] = ffbsa_pkg::BLOCK_SIZE_RST;
        phase_bsize[1] = 65535;
        phase_bsize[2] = $urandom_range(16, 600);
        phase_bsize[3] = 1;
        phase_bsize[4] = $urandom_range(1, 65535);
        phase_items    = '{150, 100, 120, 100, 150};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIR_N; n++)
        begin
            issue_request(dir_tbl[n].rq, dir_tbl[n].known, dir_tbl[n].exp);
            after_transfer(n == DIR_N - 1);
        end

        for (p = 0; p < N_PHASE; p++)
        begin
            set_block_size(phase_bsize[p]);
            calm = (p == 2);
            for (n = 0; n < phase_items[p]; n++)
            begin
                // long receiver hold-off so the block backs up into the request side
                if (p == 0 && n == 40)
                    hold_left = 500;
                issue_request(pick_request(), 1'b0, '0);
                after_transfer(n == phase_items[p] - 1);
            end
        end
        calm = 1'b0;

        while (want_rsp_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Sent %0d requests over %0d block sizes (last %0d), %0d blocks open at end.",
                 n_sent, N_PHASE, map_bsize, map_open);
        $display("Responses: %0d ok, %0d no space, %0d bad release; %0d mismatches.",
                 n_ok, n_nospace, n_badrel, err_cnt);
        if (err_cnt == 0)
            $display("** first_fit_block_space_allocator_top: PASSED **");
        else
            $display("** first_fit_block_space_allocator_top: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
hdl/ffbsa_pkg.sv
hdl/ffbsa_cell.sv
hdl/first_fit_block_space_allocator_top.sv
dv/testbench.sv
